/* src/edf_pkg.sv */
`timescale 1ns / 1ps

package edf_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_BITS  = $clog2(MAX_TASKS);
    localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;

    // controller to datapath
    typedef struct packed {
        logic                start;  // transfer taken: clear the scan result
        logic                load;   // transfer is a load: write the slot
        logic                step;   // visit slot idx
        logic                fix;    // settle the granted slot
        logic                emit;   // capture the result into the output register
        logic [IDX_BITS-1:0] idx;
    } t_dp_cmd;

endpackage

/* src/edf_tick_scheduler_core.sv */
`timescale 1ns / 1ps
// Load: the slot is written as the transfer is taken; the EMIT state then captures the result.
// Tick: the SCAN state visits each active slot in turn (task_count capped at 16), then
//   the FIX and EMIT states follow; with no active slots the scan is skipped.
//   In either case the next input is taken in IDLE, after the result has been emitted.
// A held result register stalls emit and the input.
// Reset (synchronous, active low) clears all task tables, counters and task_count.
module edf_tick_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [3:0]  i_task_index,
    input  logic [15:0] i_exec_time,
    input  logic [15:0] i_rel_deadline,
    input  logic [15:0] i_period_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_idle,
    output logic [3:0]  o_running_task,
    output logic [15:0] o_miss_mask
);
    import edf_pkg::*;

    t_dp_cmd w_cmd;

    edf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    edf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_task_index   (i_task_index),
        .i_exec_time    (i_exec_time),
        .i_rel_deadline (i_rel_deadline),
        .i_period_len   (i_period_len),
        .o_idle         (o_idle),
        .o_running_task (o_running_task),
        .o_miss_mask    (o_miss_mask)
    );

    a_no_step_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_cmd.step && !w_cmd.fix)
        else $error("scan active while accepting input");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

    a_load_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !w_cmd.step && !w_cmd.fix)
        else $error("load started a scan");

    a_idle_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_idle |-> o_running_task == 4'h0)
        else $error("idle result with nonzero task");

endmodule

/* src/edf_ctrl.sv */
`timescale 1ns / 1ps

module edf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_data,
    input  logic            i_in_valid,
    input  logic            i_op,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output edf_pkg::t_dp_cmd o_cmd
);
    import edf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIX, S_EMIT} t_state;

    t_state              r_state;
    logic [4:0]          r_task_count;
    logic [CNT_BITS-1:0] r_j;
    logic                r_out_valid;
    logic [CNT_BITS-1:0] n_active;
    logic                n_accept;
    logic                n_emit;

    // task_count above the slot count acts as the slot count
    always_comb begin
        if (32'(r_task_count) > MAX_TASKS) begin
            n_active = CNT_BITS'(MAX_TASKS);
        end else begin
            n_active = CNT_BITS'(r_task_count);
        end
    end

    assign n_accept = i_in_valid && (r_state == S_IDLE);
    assign n_emit   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd       = '0;
        o_cmd.start = n_accept;
        o_cmd.load  = n_accept && (i_op == OP_LOAD);
        o_cmd.step  = (r_state == S_SCAN);
        o_cmd.fix   = (r_state == S_FIX);
        o_cmd.emit  = n_emit;
        o_cmd.idx   = r_j[IDX_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_task_count <= i_cfg_data;
            end
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_j <= '0;
                        if (i_op == OP_LOAD) begin
                            r_state <= S_EMIT;
                        end else if (n_active == '0) begin
                            r_state <= S_FIX;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_j == n_active - 1'b1) begin
                        r_state <= S_FIX;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_FIX: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (n_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/edf_dpath.sv */
`timescale 1ns / 1ps

module edf_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  edf_pkg::t_dp_cmd i_cmd,
    input  logic [3:0]       i_task_index,
    input  logic [15:0]      i_exec_time,
    input  logic [15:0]      i_rel_deadline,
    input  logic [15:0]      i_period_len,
    output logic             o_idle,
    output logic [3:0]       o_running_task,
    output logic [15:0]      o_miss_mask
);
    import edf_pkg::*;

    t_time r_etab  [MAX_TASKS];
    t_time r_dtab  [MAX_TASKS];
    t_time r_ptab  [MAX_TASKS];
    t_time r_dleft [MAX_TASKS];
    t_time r_wleft [MAX_TASKS];
    t_time r_phase [MAX_TASKS];

    // scan result
    logic                r_found;
    logic [IDX_BITS-1:0] r_best;
    t_time               r_best_d;
    t_time               r_best_w;
    logic                r_best_bnd;
    logic                r_best_miss;
    logic [15:0]         r_mask;

    logic [IDX_BITS-1:0] n_widx;
    logic                n_load_ok;
    t_time               n_e, n_d, n_p;
    t_time               n_cur_d, n_cur_w;
    logic                n_bnd;
    logic                n_cand;
    logic [15:0]         n_bit;
    logic [15:0]         n_best_bit;

    assign n_widx    = IDX_BITS'(i_task_index);
    assign n_load_ok = (32'(i_task_index) < MAX_TASKS);
    assign n_e       = i_exec_time[TIME_BITS-1:0];
    assign n_d       = i_rel_deadline[TIME_BITS-1:0];
    assign n_p       = (i_period_len[TIME_BITS-1:0] == '0) ? t_time'(1)
                                                           : i_period_len[TIME_BITS-1:0];

    assign n_cur_d    = r_dleft[i_cmd.idx];
    assign n_cur_w    = r_wleft[i_cmd.idx];
    assign n_bnd      = (r_phase[i_cmd.idx] == r_ptab[i_cmd.idx] - 1'b1);
    assign n_cand     = (n_cur_w != '0) && (!r_found || n_cur_d < r_best_d);
    assign n_bit      = 16'(1) << i_cmd.idx;
    assign n_best_bit = 16'(1) << r_best;

    // slot state; a slot is updated as if not granted, fixed up after the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_etab[k]  <= '0;
                r_dtab[k]  <= '0;
                r_ptab[k]  <= '0;
                r_dleft[k] <= '0;
                r_wleft[k] <= '0;
                r_phase[k] <= '0;
            end
        end else begin
            if (i_cmd.load && n_load_ok) begin
                r_etab[n_widx]  <= n_e;
                r_dtab[n_widx]  <= n_d;
                r_ptab[n_widx]  <= n_p;
                r_dleft[n_widx] <= n_d;
                r_wleft[n_widx] <= n_e;
                r_phase[n_widx] <= '0;
            end
            if (i_cmd.step) begin
                if (n_bnd) begin
                    r_dleft[i_cmd.idx] <= r_dtab[i_cmd.idx];
                    r_wleft[i_cmd.idx] <= r_etab[i_cmd.idx];
                    r_phase[i_cmd.idx] <= '0;
                end else begin
                    if (n_cur_d != '0) begin
                        r_dleft[i_cmd.idx] <= n_cur_d - 1'b1;
                    end
                    r_phase[i_cmd.idx] <= r_phase[i_cmd.idx] + 1'b1;
                end
            end
            if (i_cmd.fix && r_found && !r_best_bnd) begin
                r_wleft[r_best] <= r_best_w - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_mask  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_found <= 1'b0;
                r_mask  <= '0;
            end
            if (i_cmd.step) begin
                if (!n_bnd && n_cur_d == '0 && n_cur_w != '0) begin
                    r_mask <= r_mask | n_bit;
                end
                if (n_cand) begin
                    r_found     <= 1'b1;
                    r_best      <= i_cmd.idx;
                    r_best_d    <= n_cur_d;
                    r_best_w    <= n_cur_w;
                    r_best_bnd  <= n_bnd;
                    r_best_miss <= (n_cur_d == '0) && (n_cur_w != t_time'(1));
                end
            end
            // replace the granted slot's miss bit with its value after the grant
            if (i_cmd.fix && r_found && !r_best_bnd) begin
                r_mask <= (r_mask & ~n_best_bit) | (r_best_miss ? n_best_bit : 16'h0000);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_idle         <= !r_found;
            o_running_task <= r_found ? 4'(r_best) : 4'h0;
            o_miss_mask    <= r_mask;
        end
    end

endmodule
